### design/cfpm_pkg.sv
`timescale 1ns / 1ps

package cfpm_pkg;

    localparam int unsigned TUS_W      = 48;
    localparam int unsigned TMS_W      = 32;
    localparam int unsigned WORD_W     = 32;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 20;

    typedef enum logic [1:0] {
        OP_PULSE = 2'd0,
        OP_TICK  = 2'd1,
        OP_REARM = 2'd2
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PULSE_ENERGY = 2'd0,
        CFG_IDLE_TIMEOUT = 2'd1,
        CFG_RATE_WINDOW  = 2'd2
    } t_cfg_idx;

    localparam logic [CFG_DATA_W-1:0] RST_PULSE_ENERGY = 20'd475;
    localparam logic [CFG_DATA_W-1:0] RST_IDLE_TIMEOUT = 20'd10000;
    localparam logic [CFG_DATA_W-1:0] RST_RATE_WINDOW  = 20'd60000;

    // 60 s/min * 16 * 1000 ms/s
    localparam int unsigned RATE_SCALE_W = 20;
    localparam logic [RATE_SCALE_W-1:0] RATE_SCALE = 20'd960000;
    // 3600 s/h * 10 tenths / 1 uWh per uW
    localparam int unsigned POWER_SCALE_W = 16;
    localparam logic [POWER_SCALE_W-1:0] POWER_SCALE = 16'd36000;

    localparam int unsigned DIV_Q_W    = 32;
    localparam int unsigned DIV_N_W    = 2 * DIV_Q_W;
    localparam int unsigned DIV_STEP_W = $clog2(DIV_Q_W);

    typedef struct packed {
        t_op              op;
        logic [TUS_W-1:0] time_us;
        logic [TMS_W-1:0] time_ms;
    } t_item;

    typedef struct packed {
        logic [WORD_W-1:0] power_tenths;
        logic [WORD_W-1:0] record_index;
        logic [WORD_W-1:0] pulses_per_min_x16;
        logic              rate_updated;
        logic [WORD_W-1:0] ms_since_pulse;
        logic [WORD_W-1:0] pulse_total;
    } t_result;

    typedef struct packed {
        logic               start;
        logic [DIV_N_W-1:0] num;
        logic [DIV_Q_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic [DIV_Q_W-1:0] quot;
    } t_div_rsp;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RATE_MUL,
        ST_RATE_GO,
        ST_RATE_WAIT,
        ST_PWR_MUL,
        ST_PWR_GO,
        ST_PWR_WAIT,
        ST_EMIT
    } t_back_state;

endpackage

### design/cfpm_ifs.sv
`timescale 1ns / 1ps

interface cfpm_item_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  op;
    logic [cfpm_pkg::TUS_W-1:0]  time_us;
    logic [cfpm_pkg::TMS_W-1:0]  time_ms;

    modport source (output valid, op, time_us, time_ms, input ready);
    modport sink   (input valid, op, time_us, time_ms, output ready);
endinterface

interface cfpm_result_if;
    logic                        valid;
    logic                        ready;
    logic [cfpm_pkg::WORD_W-1:0] power_tenths;
    logic [cfpm_pkg::WORD_W-1:0] record_index;
    logic [cfpm_pkg::WORD_W-1:0] pulses_per_min_x16;
    logic                        rate_updated;
    logic [cfpm_pkg::WORD_W-1:0] ms_since_pulse;
    logic [cfpm_pkg::WORD_W-1:0] pulse_total;

    modport source (output valid, power_tenths, record_index, pulses_per_min_x16,
                    rate_updated, ms_since_pulse, pulse_total, input ready);
    modport sink   (input valid, power_tenths, record_index, pulses_per_min_x16,
                    rate_updated, ms_since_pulse, pulse_total, output ready);
endinterface

interface cfpm_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [cfpm_pkg::CFG_IDX_W-1:0]  index;
    logic [cfpm_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### design/cf_pulse_power_meter.sv
`timescale 1ns / 1ps

// Pulse-interval power meter. Items enter a small queue (QUEUE_DEPTH entries)
// and are executed one at a time; the input side keeps accepting while the
// queue has room, and a finished result sits in an output register until taken.
// A pulse edge or re-arm is executed as it is popped. A sample tick runs the
// rate division only when it closes the rate window, then the power division;
// each division runs on one shared 32-step serial divider. An idle meter skips
// the power division, a quotient that saturates returns in the cycle after its
// start, and a tick waits in its emit state while the previous result is still
// untaken. Unused op codes are accepted and dropped. Configuration writes are
// always accepted and take effect at once; write them only while no work is
// in flight. STALE_GAP_US sets the longest pulse gap that still updates the
// interval average.
module cf_pulse_power_meter #(
    parameter int unsigned STALE_GAP_US = 60000000,
    parameter int unsigned QUEUE_DEPTH  = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    cfpm_item_if.sink     i_item,
    cfpm_result_if.source o_result,
    cfpm_cfg_if.sink      i_cfg
);

    logic               w_head_valid;
    cfpm_pkg::t_item    w_head;
    logic               w_pop;
    cfpm_pkg::t_div_req w_div_req;
    cfpm_pkg::t_div_rsp w_div_rsp;

    cfpm_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (i_item),
        .i_pop        (w_pop),
        .o_head_valid (w_head_valid),
        .o_head       (w_head)
    );

    cfpm_back #(
        .STALE_GAP_US (STALE_GAP_US)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (i_cfg),
        .i_head_valid (w_head_valid),
        .i_head       (w_head),
        .o_pop        (w_pop),
        .o_result     (o_result),
        .o_div_req    (w_div_req),
        .i_div_rsp    (w_div_rsp)
    );

    cfpm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

endmodule

### design/cfpm_front.sv
`timescale 1ns / 1ps

// QUEUE_DEPTH range 2..16
module cfpm_front #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    cfpm_item_if.sink         i_item,
    input  logic              i_pop,
    output logic              o_head_valid,
    output cfpm_pkg::t_item   o_head
);

    localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    cfpm_pkg::t_item  r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    logic w_known_op;
    logic w_push;
    logic w_pop;

    // unused op code is accepted and dropped here
    assign w_known_op = (i_item.op == cfpm_pkg::OP_PULSE) ||
                        (i_item.op == cfpm_pkg::OP_TICK)  ||
                        (i_item.op == cfpm_pkg::OP_REARM);

    assign i_item.ready = (r_count != CNT_W'(QUEUE_DEPTH));
    assign w_push       = i_item.valid && i_item.ready && w_known_op;
    assign w_pop        = i_pop && (r_count != '0);

    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_mem[r_wr_ptr] <= '{op:      cfpm_pkg::t_op'(i_item.op),
                                     time_us: i_item.time_us,
                                     time_ms: i_item.time_ms};
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!w_push && w_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

### design/cfpm_div.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle. Quotient saturates to all ones
// when it would not fit in DIV_Q_W bits.
module cfpm_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  cfpm_pkg::t_div_req i_req,
    output cfpm_pkg::t_div_rsp o_rsp
);

    localparam int unsigned QW = cfpm_pkg::DIV_Q_W;
    localparam int unsigned SW = cfpm_pkg::DIV_STEP_W;

    logic          r_busy;
    logic          r_done;
    logic [SW-1:0] r_step;
    logic [QW-1:0] r_rem;
    logic [QW-1:0] r_lo;
    logic [QW-1:0] r_quot;
    logic [QW-1:0] r_den;

    logic [QW:0]   w_trial;

    assign w_trial = {r_rem, r_lo[QW-1]} - {1'b0, r_den};

    assign o_rsp = '{done: r_done, quot: r_quot};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                if (i_req.num[2*QW-1:QW] >= i_req.den) begin
                    r_quot <= '1;
                    r_done <= 1'b1;
                    r_busy <= 1'b0;
                end else begin
                    r_rem  <= i_req.num[2*QW-1:QW];
                    r_lo   <= i_req.num[QW-1:0];
                    r_den  <= i_req.den;
                    r_step <= SW'(QW - 1);
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                if (!w_trial[QW]) begin
                    r_rem <= w_trial[QW-1:0];
                end else begin
                    r_rem <= {r_rem[QW-2:0], r_lo[QW-1]};
                end
                r_quot <= {r_quot[QW-2:0], ~w_trial[QW]};
                r_lo   <= {r_lo[QW-2:0], 1'b0};
                if (r_step == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_step <= r_step - 1'b1;
                end
            end
        end
    end

endmodule

### design/cfpm_back.sv
`timescale 1ns / 1ps

module cfpm_back #(
    parameter int unsigned STALE_GAP_US = 60000000
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    cfpm_cfg_if.sink           i_cfg,
    input  logic               i_head_valid,
    input  cfpm_pkg::t_item    i_head,
    output logic               o_pop,
    cfpm_result_if.source      o_result,
    output cfpm_pkg::t_div_req o_div_req,
    input  cfpm_pkg::t_div_rsp i_div_rsp
);

    localparam int unsigned TUS_W = cfpm_pkg::TUS_W;
    localparam int unsigned W     = cfpm_pkg::WORD_W;
    localparam int unsigned DW    = cfpm_pkg::CFG_DATA_W;
    localparam int unsigned NW    = cfpm_pkg::DIV_N_W;
    localparam int unsigned RPW   = W + cfpm_pkg::RATE_SCALE_W;
    localparam int unsigned PPW   = DW + cfpm_pkg::POWER_SCALE_W;

    cfpm_pkg::t_back_state r_state, n_state;

    logic [DW-1:0]    r_pulse_energy;
    logic [DW-1:0]    r_idle_timeout;
    logic [DW-1:0]    r_rate_window;

    logic [TUS_W-1:0] r_last_edge_us;
    logic [W-1:0]     r_avg;
    logic [W-1:0]     r_idle_ref;
    logic [W-1:0]     r_true_pulse;
    logic             r_seen;
    logic [W-1:0]     r_edge_count;
    logic [W-1:0]     r_win_count;
    logic [W-1:0]     r_win_ms;
    logic [W-1:0]     r_rate_hold;
    logic [W-1:0]     r_sample_seq;

    logic [W-1:0]     r_tms;
    logic [W-1:0]     r_elapsed;
    logic [W-1:0]     r_delta;
    logic             r_win_hit;
    logic             r_updated;
    logic [W-1:0]     r_power;
    logic [NW-1:0]    r_num;
    logic [W-1:0]     r_den;

    logic                  r_out_valid;
    cfpm_pkg::t_result     r_out;

    logic             w_div_start;
    logic             w_out_free;
    logic             w_idle;
    logic [TUS_W-1:0] w_gap;
    logic             w_gap_ok;
    logic [W+1:0]     w_avg_sum;
    logic [W-1:0]     w_head_elapsed;
    logic [W-1:0]     w_window;
    logic [RPW-1:0]   w_rate_prod;
    logic [PPW-1:0]   w_pwr_prod;

    assign i_cfg.ready = 1'b1;

    assign w_out_free = !r_out_valid || o_result.ready;
    assign w_idle     = (r_avg == '0) || ((r_tms - r_idle_ref) > W'(r_idle_timeout));

    assign w_gap     = i_head.time_us - r_last_edge_us;
    assign w_gap_ok  = (w_gap != '0) && (w_gap <= TUS_W'(STALE_GAP_US));
    // stale limit stays below 2^30, so the sum fits and /4 fits in 32 bits
    assign w_avg_sum = (W+2)'(r_avg) + (W+2)'({r_avg, 1'b0}) + (W+2)'(w_gap[W-1:0]);

    assign w_window       = (r_rate_window == '0) ? W'(1) : W'(r_rate_window);
    assign w_head_elapsed = i_head.time_ms - r_win_ms;

    assign w_rate_prod = RPW'(r_delta) * RPW'(cfpm_pkg::RATE_SCALE);
    assign w_pwr_prod  = PPW'(r_pulse_energy) * PPW'(cfpm_pkg::POWER_SCALE);

    assign o_div_req = '{start: w_div_start, num: r_num, den: r_den};

    assign o_result.valid              = r_out_valid;
    assign o_result.power_tenths       = r_out.power_tenths;
    assign o_result.record_index       = r_out.record_index;
    assign o_result.pulses_per_min_x16 = r_out.pulses_per_min_x16;
    assign o_result.rate_updated       = r_out.rate_updated;
    assign o_result.ms_since_pulse     = r_out.ms_since_pulse;
    assign o_result.pulse_total        = r_out.pulse_total;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cfpm_pkg::ST_IDLE: begin
                if (i_head_valid && (i_head.op == cfpm_pkg::OP_TICK)) begin
                    n_state = cfpm_pkg::ST_RATE_MUL;
                end
            end
            cfpm_pkg::ST_RATE_MUL: begin
                n_state = r_win_hit ? cfpm_pkg::ST_RATE_GO : cfpm_pkg::ST_PWR_MUL;
            end
            cfpm_pkg::ST_RATE_GO:   n_state = cfpm_pkg::ST_RATE_WAIT;
            cfpm_pkg::ST_RATE_WAIT: begin
                if (i_div_rsp.done) begin
                    n_state = cfpm_pkg::ST_PWR_MUL;
                end
            end
            cfpm_pkg::ST_PWR_MUL: begin
                n_state = w_idle ? cfpm_pkg::ST_EMIT : cfpm_pkg::ST_PWR_GO;
            end
            cfpm_pkg::ST_PWR_GO:    n_state = cfpm_pkg::ST_PWR_WAIT;
            cfpm_pkg::ST_PWR_WAIT: begin
                if (i_div_rsp.done) begin
                    n_state = cfpm_pkg::ST_EMIT;
                end
            end
            cfpm_pkg::ST_EMIT: begin
                if (w_out_free) begin
                    n_state = cfpm_pkg::ST_IDLE;
                end
            end
            default: n_state = cfpm_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_pop       = 1'b0;
        w_div_start = 1'b0;
        unique case (r_state)
            cfpm_pkg::ST_IDLE:     o_pop       = i_head_valid;
            cfpm_pkg::ST_RATE_GO,
            cfpm_pkg::ST_PWR_GO:   w_div_start = 1'b1;
            default: begin
                o_pop       = 1'b0;
                w_div_start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= cfpm_pkg::ST_IDLE;
            r_out_valid    <= 1'b0;
            r_pulse_energy <= cfpm_pkg::RST_PULSE_ENERGY;
            r_idle_timeout <= cfpm_pkg::RST_IDLE_TIMEOUT;
            r_rate_window  <= cfpm_pkg::RST_RATE_WINDOW;
            r_last_edge_us <= '0;
            r_avg          <= '0;
            r_idle_ref     <= '0;
            r_true_pulse   <= '0;
            r_seen         <= 1'b0;
            r_edge_count   <= '0;
            r_win_count    <= '0;
            r_win_ms       <= '0;
            r_rate_hold    <= '0;
            r_sample_seq   <= W'(1);
        end else begin
            r_state <= n_state;

            if (i_cfg.valid) begin
                if (i_cfg.index == cfpm_pkg::CFG_PULSE_ENERGY) begin
                    r_pulse_energy <= i_cfg.data;
                end else if (i_cfg.index == cfpm_pkg::CFG_IDLE_TIMEOUT) begin
                    r_idle_timeout <= i_cfg.data;
                end else if (i_cfg.index == cfpm_pkg::CFG_RATE_WINDOW) begin
                    r_rate_window <= i_cfg.data;
                end
            end

            if ((r_state == cfpm_pkg::ST_EMIT) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && o_result.ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                cfpm_pkg::ST_IDLE: begin
                    if (i_head_valid) begin
                        unique case (i_head.op)
                            cfpm_pkg::OP_PULSE: begin
                                r_last_edge_us <= i_head.time_us;
                                r_idle_ref     <= i_head.time_ms;
                                r_true_pulse   <= i_head.time_ms;
                                r_seen         <= 1'b1;
                                r_edge_count   <= r_edge_count + 1'b1;
                                if (w_gap_ok) begin
                                    r_avg <= (r_avg == '0) ? w_gap[W-1:0]
                                                           : w_avg_sum[W+1:2];
                                end
                            end
                            cfpm_pkg::OP_REARM: begin
                                r_last_edge_us <= i_head.time_us;
                                r_avg          <= '0;
                                r_idle_ref     <= i_head.time_ms;
                            end
                            cfpm_pkg::OP_TICK: begin
                                r_tms     <= i_head.time_ms;
                                r_elapsed <= w_head_elapsed;
                                r_delta   <= r_edge_count - r_win_count;
                                r_win_hit <= (w_head_elapsed >= w_window);
                                r_updated <= 1'b0;
                            end
                            default: r_updated <= 1'b0;
                        endcase
                    end
                end
                cfpm_pkg::ST_RATE_MUL: begin
                    // round half up: add elapsed/2 before dividing
                    r_num <= NW'(w_rate_prod) + NW'(r_elapsed[W-1:1]);
                    r_den <= r_elapsed;
                end
                cfpm_pkg::ST_RATE_WAIT: begin
                    if (i_div_rsp.done) begin
                        r_rate_hold <= i_div_rsp.quot;
                        r_win_count <= r_edge_count;
                        r_win_ms    <= r_tms;
                        r_updated   <= 1'b1;
                    end
                end
                cfpm_pkg::ST_PWR_MUL: begin
                    if (w_idle) begin
                        r_avg   <= '0;
                        r_power <= '0;
                    end else begin
                        r_num <= NW'(w_pwr_prod) + NW'(r_avg[W-1:1]);
                        r_den <= r_avg;
                    end
                end
                cfpm_pkg::ST_PWR_WAIT: begin
                    if (i_div_rsp.done) begin
                        r_power <= i_div_rsp.quot;
                    end
                end
                cfpm_pkg::ST_EMIT: begin
                    if (w_out_free) begin
                        r_sample_seq <= r_sample_seq + 1'b1;
                        r_out <= '{power_tenths:       r_power,
                                   record_index:       r_sample_seq + 1'b1,
                                   pulses_per_min_x16: r_rate_hold,
                                   rate_updated:       r_updated,
                                   ms_since_pulse:     r_seen ? (r_tms - r_true_pulse) : '1,
                                   pulse_total:        r_edge_count};
                    end
                end
                default: r_updated <= r_updated;
            endcase
        end
    end

endmodule

### design/cfpm_checker.sv
`timescale 1ns / 1ps

module cfpm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_res_valid,
    input logic        i_res_ready,
    input logic [31:0] i_power_tenths,
    input logic [31:0] i_record_index,
    input logic [31:0] i_pulses_per_min_x16,
    input logic        i_rate_updated,
    input logic [31:0] i_ms_since_pulse,
    input logic [31:0] i_pulse_total
);

    logic        w_res_acc;
    logic [31:0] r_last_index;
    logic [31:0] r_last_rate;

    assign w_res_acc = i_res_valid && i_res_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_index <= 32'd1;
            r_last_rate  <= '0;
        end else if (w_res_acc) begin
            r_last_index <= i_record_index;
            r_last_rate  <= i_pulses_per_min_x16;
        end
    end

    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid)
        else $error("result valid dropped while stalled");

    a_payload_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=>
            $stable({i_power_tenths, i_record_index, i_pulses_per_min_x16,
                     i_rate_updated, i_ms_since_pulse, i_pulse_total}))
        else $error("result payload changed while stalled");

    a_index_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_acc |-> i_record_index == r_last_index + 32'd1)
        else $error("record index did not advance by one");

    a_rate_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_acc && !i_rate_updated |-> i_pulses_per_min_x16 == r_last_rate)
        else $error("pulse rate changed without a window close");

endmodule

bind cf_pulse_power_meter cfpm_checker u_cfpm_checker (
    .i_clk                (i_clk),
    .i_rst_n              (i_rst_n),
    .i_res_valid          (o_result.valid),
    .i_res_ready          (o_result.ready),
    .i_power_tenths       (o_result.power_tenths),
    .i_record_index       (o_result.record_index),
    .i_pulses_per_min_x16 (o_result.pulses_per_min_x16),
    .i_rate_updated       (o_result.rate_updated),
    .i_ms_since_pulse     (o_result.ms_since_pulse),
    .i_pulse_total        (o_result.pulse_total)
);
